// ----- hw/rtl/sha_pkg.sv -----
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // front-to-back command: at most one byte to absorb, optionally closing the message
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_OUT
  } sha_state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hw/rtl/sha_front.sv -----
`timescale 1ns / 1ps
module sha_front
  import sha_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  sha_in_t  in_item,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output sha_cmd_t cmd
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  sha_cmd_t         q_r [QUEUE_DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             wr, rd, useful;

  // beats with neither byte nor end carry no work and are dropped here
  assign useful    = in_item.byte_present | in_item.end_of_message;
  assign full      = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign wr        = push & ~full & useful;
  assign rd        = cmd_take & cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= '{data_byte: in_item.data_byte, byte_present: in_item.byte_present,
                     end_of_message: in_item.end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ----- hw/rtl/sha_core.sv -----
`timescale 1ns / 1ps
module sha_core
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_take,
  input  sha_cmd_t cmd,
  output logic     out_empty,
  input  logic     out_pop,
  output sha_out_t out_item
);

  sha_state_t   state_r, state_nxt, ret_r;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [63:0]  len_r, len_lat_r;
  logic [5:0]   fill_r;
  logic [5:0]   rnd_r;
  logic [2:0]   lcnt_r, oidx_r;
  logic         ending_r;

  logic         put;
  logic [7:0]   put_byte;
  logic         comp_last, out_last, blk_full;
  logic [31:0]  s0, s1, w_new, big0, big1, ch, mj, t1, t2;

  assign blk_full  = (fill_r == 6'd63);
  assign comp_last = (rnd_r == 6'd63);
  assign out_last  = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_valid) begin
        if (cmd.byte_present && blk_full) state_nxt = ST_COMP;
        else if (cmd.end_of_message) state_nxt = ST_PAD;
      end
      ST_PAD: begin
        if (blk_full) state_nxt = ST_COMP;
        else if (fill_r == 6'd55 || (fill_r == 6'd56 && ret_r == ST_LEN)) state_nxt = ST_LEN;
      end
      ST_LEN: if (blk_full) state_nxt = ST_COMP;
      ST_COMP: if (comp_last) state_nxt = ret_r;
      ST_OUT: if (out_pop && out_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = 1'b0;
    put      = 1'b0;
    put_byte = 8'h00;
    unique case (state_r)
      ST_IDLE: begin
        cmd_take = cmd_valid;
        put      = cmd_valid & cmd.byte_present;
        put_byte = cmd.data_byte;
      end
      ST_PAD: begin
        put      = ~(fill_r == 6'd56 && ret_r == ST_LEN);
        put_byte = ending_r ? PAD_MARK : 8'h00;
      end
      ST_LEN: begin
        put      = 1'b1;
        put_byte = len_lat_r[8*(7-lcnt_r) +: 8];
      end
      default: ;
    endcase
  end

  assign out_empty = (state_r != ST_OUT);
  assign out_item  = '{digest_word: h_r[oidx_r], word_index: oidx_r, last_word: out_last};

  // schedule kept as a 16-word shift window
  assign s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;
  assign big1  = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
  assign ch    = (e_r & f_r) ^ (~e_r & g_r);
  assign t1    = hh_r + big1 + ch + ROUND_K[rnd_r] + w_r[0];
  assign big0  = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
  assign mj    = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
  assign t2    = big0 + mj;

  always_ff @(posedge clk) begin
    if (put) begin
      unique case (fill_r[1:0])
        2'd0: w_r[fill_r[5:2]] <= {put_byte, 24'h0};
        2'd1: w_r[fill_r[5:2]][23:16] <= put_byte;
        2'd2: w_r[fill_r[5:2]][15:8] <= put_byte;
        default: w_r[fill_r[5:2]][7:0] <= put_byte;
      endcase
    end else if (state_r == ST_COMP) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (state_r != ST_COMP && state_nxt == ST_COMP) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
      e_r <= h_r[4]; f_r <= h_r[5]; g_r <= h_r[6]; hh_r <= h_r[7];
    end else if (state_r == ST_COMP) begin
      hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
    if (state_r == ST_IDLE && cmd_valid && cmd.end_of_message) begin
      len_lat_r <= len_r + (cmd.byte_present ? 64'd8 : 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      fill_r   <= '0;
      len_r    <= '0;
      rnd_r    <= '0;
      lcnt_r   <= '0;
      oidx_r   <= '0;
      ending_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
    end else begin
      state_r <= state_nxt;
      if (put) fill_r <= fill_r + 1'b1;
      if (state_r == ST_IDLE && cmd_valid) begin
        if (cmd.end_of_message) len_r <= '0;
        else if (cmd.byte_present) len_r <= len_r + 64'd8;
        ending_r <= 1'b1;
        // where to resume after a block compressed mid-command
        ret_r <= cmd.end_of_message ? ST_PAD : ST_IDLE;
      end
      if (state_r == ST_PAD && put) ending_r <= 1'b0;
      if (state_r == ST_PAD && state_nxt == ST_COMP) ret_r <= ST_PAD;
      if (state_r == ST_PAD && state_nxt == ST_LEN) lcnt_r <= '0;
      if (state_r == ST_LEN) begin
        lcnt_r <= lcnt_r + 1'b1;
        if (blk_full) ret_r <= ST_OUT;
      end
      if (state_r == ST_COMP) begin
        rnd_r <= rnd_r + 1'b1;
        if (comp_last) begin
          h_r[0] <= h_r[0] + t1 + t2; h_r[1] <= h_r[1] + a_r;
          h_r[2] <= h_r[2] + b_r;     h_r[3] <= h_r[3] + c_r;
          h_r[4] <= h_r[4] + d_r + t1; h_r[5] <= h_r[5] + e_r;
          h_r[6] <= h_r[6] + f_r;     h_r[7] <= h_r[7] + g_r;
        end
      end else begin
        rnd_r <= '0;
      end
      if (state_r == ST_OUT && out_pop) begin
        oidx_r <= oidx_r + 1'b1;
        if (out_last) begin
          for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
          fill_r <= '0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/sha256_message_hasher_top.sv -----
`timescale 1ns / 1ps
// SHA-256 hasher taking one message byte per beat; an end mark (with or without
// a byte) pads the message and yields eight digest beats H0..H7, after which
// the hash restarts. Every 64th byte starts a compression on the single round
// unit, during which bytes queue in the front FIFO (QUEUE_DEPTH entries).
// Padding writes the pad and length bytes one at a time and needs one or two
// compressions; digest beats leave one per pop.
module sha256_message_hasher_top
  import sha_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  sha_in_t  in_item,
  output logic     empty,
  input  logic     pop,
  output sha_out_t out_item
);

  logic     cmd_valid, cmd_take;
  sha_cmd_t cmd;

  sha_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  sha_core u_core (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_empty(empty), .out_pop(pop), .out_item(out_item)
  );

endmodule

// ----- sim/sha256_message_hasher_top_test.sv -----
`timescale 1ns / 1ps
module sha256_message_hasher_top_test;
  import sha_pkg::*;

  class sha_scoreboard;
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [63:0] nbits;
    logic [5:0]  fill;
    sha_out_t    digest_q [$];
    int          errors;
    int          words_seen;
    int          msgs;

    function new();
      errors = 0;
      words_seen = 0;
      msgs = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hv[i] = INIT_HASH[i];
      nbits = '0;
      fill = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hv[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hv[i] += v[i];
    endfunction

    function void absorb(logic [7:0] b);
      logic [1:0] pos;
      pos = fill[1:0];
      if (pos == 2'd0) blk[fill[5:2]] = {b, 24'h0};
      else blk[fill[5:2]] |= 32'(b) << (8 * (3 - pos));
      fill = fill + 6'd1;
      if (fill == 6'd0) compress();
    endfunction

    function void note(sha_in_t it);
      logic [63:0] len;
      sha_out_t o;
      if (it.byte_present) begin
        absorb(it.data_byte);
        nbits += 64'd8;
      end
      if (!it.end_of_message) return;
      len = nbits;
      absorb(PAD_MARK);
      while (fill != 6'd56) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(len[8*(7-i) +: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hv[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        digest_q.insert(digest_q.size(), o);
      end
      msgs++;
      restart();
    endfunction

    function void check(sha_out_t got);
      sha_out_t exp_w;
      words_seen++;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest beat %h", got);
        return;
      end
      exp_w = digest_q.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: exp word %h idx %0d last %0d, got word %h idx %0d last %0d",
                   exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full, empty;
  sha_in_t  in_item = '0;
  sha_out_t out_item;

  sha_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int byte_items = 0;
  int quiet_cycles = 0;
  localparam int QUIET_LIMIT = 6000;

  sha256_message_hasher_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check(out_item);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("sha256_message_hasher_top_test: FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] d, logic present, logic eom);
    sha_in_t it;
    it.data_byte = d;
    it.byte_present = present;
    it.end_of_message = eom;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      in_item <= '{data_byte: 8'($urandom), byte_present: 1'($urandom),
                   end_of_message: 1'($urandom)};
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note(it);
    if (present) byte_items++;
  endtask

  task automatic send_message(int len, bit end_with_byte, int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    end
    if (!end_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  int total_items;
  int len;
  int phase;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, extreme single bytes, idle beat, "abc"
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);

    total_items = 0;
    while (total_items < 230) begin
      phase = total_items / 58;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (total_items >= 20 && hold_left == 0 && !hold_done) begin
        hold_left = 500;
        hold_done = 1'b1;
      end
      case ($urandom_range(9))
        0, 1: len = 55 + $urandom_range(10);
        2: len = 119 + $urandom_range(2);
        default: len = $urandom_range(20);
      endcase
      send_message(len, $urandom_range(1), 10);
      total_items += len + 1;
    end
    push <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d messages, %0d message bytes, %0d digest words checked",
             sb.msgs, byte_items, sb.words_seen);
    $display("idle phases: none, sender 78%%, receiver 78%%, both 30%%, plus one long receiver hold");
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("sha256_message_hasher_top_test: PASS");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.errors, sb.digest_q.size());
      $display("sha256_message_hasher_top_test: FAIL");
    end
    $finish;
  end

endmodule
